// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the priority scheduler checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define PPS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps check failed");

// Check a consequent in the cycle after its antecedent.
`define PPS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps check failed");

`endif

// ----- hw/rtl/pps_pkg.sv -----
`timescale 1ns / 1ps
// Package: shared constants, item types and control structs of the priority scheduler.
package pps_pkg;

  localparam int SLOT_W    = 4;
  localparam int MAX_TASKS = 2 ** SLOT_W;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 10;
  localparam int FUNC_W    = 2;

  localparam logic [PRIO_W-1:0] PRIO_NONE = PRIO_W'(999);
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] priority_req;
  } item_in_t;

  typedef struct packed {
    logic              load_rejected;
    logic [TIME_W-1:0] current_time;
    logic              ran_valid;
    logic [SLOT_W-1:0] ran_slot;
    logic              finished;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround;
    logic [SLOT_W-1:0] next_slot;
    logic              switched;
    logic              all_done;
  } item_out_t;

  typedef struct packed {
    logic capture;
    logic load_exec;
    logic tick_exec;
    logic scan_run;
    logic clear_exec;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic scan_busy;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/pps_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences load, tick, scan, clear and result steps of one item.
module pps_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  logic [pps_pkg::FUNC_W-1:0] func,
  input  pps_pkg::sts_t             sts,
  output logic                      cmd_ready,
  output pps_pkg::ctl_t             ctl
);
  import pps_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_TICK  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          case (func)
            FN_LOAD:  state_next = ST_LOAD;
            FN_TICK:  state_next = ST_TICK;
            FN_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_RESP;
          endcase
        end
      end
      ST_LOAD: begin
        ctl.load_exec = 1'b1;
        state_next    = ST_RESP;
      end
      ST_TICK: begin
        ctl.tick_exec = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.scan_run = 1'b1;
        if (!sts.scan_busy) begin
          state_next = ST_RESP;
        end
      end
      ST_CLEAR: begin
        ctl.clear_exec = 1'b1;
        state_next     = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == ST_IDLE);

endmodule

// ----- hw/rtl/pps_dp.sv -----
`timescale 1ns / 1ps
// Datapath: task table memories, tick arithmetic, priority scan and result register.
module pps_dp (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::item_in_t  cmd,
  input  pps_pkg::ctl_t      ctl,
  output pps_pkg::sts_t      sts,
  input  logic               res_ready,
  output logic               res_valid,
  output pps_pkg::item_out_t res
);
  import pps_pkg::*;

  localparam int DIFF_W = TIME_W + 3;

  function automatic logic [TIME_W-1:0] clamp_time(input logic signed [DIFF_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, TIME_MAX})) begin
      r = TIME_MAX;
    end else begin
      r = v[TIME_W-1:0];
    end
    return r;
  endfunction

  logic [TIME_W-1:0] arr_mem [MAX_TASKS];
  logic [TIME_W-1:0] bur_mem [MAX_TASKS];
  logic [TIME_W-1:0] rem_mem [MAX_TASKS];
  logic [PRIO_W-1:0] pri_mem [MAX_TASKS];

  logic [TIME_W-1:0] arr_rd;
  logic [TIME_W-1:0] bur_rd;
  logic [TIME_W-1:0] rem_rd;
  logic [PRIO_W-1:0] pri_rd;

  logic [FUNC_W-1:0] func_q;
  logic [TIME_W-1:0] arr_q;
  logic [TIME_W-1:0] bur_q;
  logic [PRIO_W-1:0] pri_q;

  logic [CNT_W-1:0]     count;
  logic [TIME_W-1:0]    time_now;
  logic [SLOT_W-1:0]    sel;
  logic [MAX_TASKS-1:0] done;

  logic [CNT_W-1:0]  scan_x;
  logic              cmp_v;
  logic [SLOT_W-1:0] cmp_idx;
  logic [SLOT_W-1:0] best;
  logic [PRIO_W-1:0] best_pr;
  logic [TIME_W-1:0] best_arr;

  logic              res_rej;
  logic              res_ran;
  logic [SLOT_W-1:0] res_slot;
  logic              res_fin;
  logic [TIME_W-1:0] res_wt;
  logic [TIME_W-1:0] res_ta;
  logic              res_sw;

  logic [SLOT_W-1:0]        rd_addr;
  logic                     full;
  logic [SLOT_W-1:0]        wr_slot;
  logic                     sel_ok;
  logic                     ran_now;
  logic [TIME_W-1:0]        rem_dec;
  logic                     fin_now;
  logic [TIME_W:0]          fin_time;
  logic signed [DIFF_W-1:0] ta_raw;
  logic signed [DIFF_W-1:0] wt_raw;
  logic                     issue;
  logic                     cand_better;
  logic                     rem_we;
  logic [SLOT_W-1:0]        rem_wa;
  logic [TIME_W-1:0]        rem_wd;
  logic [MAX_TASKS-1:0]     done_or_unused;
  logic                     all_done;

  assign rd_addr = ctl.scan_run ? scan_x[SLOT_W-1:0] : sel;
  assign full    = (count == CNT_W'(MAX_TASKS));
  assign wr_slot = count[SLOT_W-1:0];

  assign sel_ok   = ({1'b0, sel} < count);
  assign ran_now  = sel_ok && (rem_rd != '0) && (arr_rd <= time_now);
  assign rem_dec  = rem_rd - TIME_W'(ran_now);
  assign fin_now  = sel_ok && (rem_dec == '0) && !done[sel];
  assign fin_time = {1'b0, time_now} + (TIME_W+1)'(1);
  assign ta_raw   = $signed({2'b00, fin_time}) - $signed({3'b000, arr_rd});
  assign wt_raw   = ta_raw - $signed({3'b000, bur_rd});

  assign issue       = (scan_x < count);
  assign cand_better = (arr_rd <= time_now) && !done[cmp_idx] &&
                       ((pri_rd < best_pr) ||
                        ((pri_rd == best_pr) && (best_pr < PRIO_NONE) && (arr_rd < best_arr)));

  assign sts.scan_busy = issue || cmp_v;
  assign sts.out_free  = !res_valid || res_ready;

  assign rem_we = (ctl.load_exec && !full) || (ctl.tick_exec && ran_now);
  assign rem_wa = ctl.load_exec ? wr_slot : sel;
  assign rem_wd = ctl.load_exec ? bur_q : rem_dec;

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      done_or_unused[i] = done[i] || (CNT_W'(i) >= count);
    end
  end
  assign all_done = &done_or_unused;

  always_ff @(posedge clk) begin
    if (ctl.load_exec && !full) begin
      arr_mem[wr_slot] <= arr_q;
      bur_mem[wr_slot] <= bur_q;
      pri_mem[wr_slot] <= pri_q;
    end
    arr_rd <= arr_mem[rd_addr];
    bur_rd <= bur_mem[rd_addr];
    pri_rd <= pri_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_rd <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      func_q  <= cmd.func;
      arr_q   <= cmd.arrival;
      bur_q   <= cmd.burst;
      pri_q   <= cmd.priority_req;
      res_rej <= 1'b0;
      res_ran <= 1'b0;
      res_fin <= 1'b0;
      res_wt  <= '0;
      res_ta  <= '0;
      res_sw  <= 1'b0;
    end
    if (ctl.load_exec) begin
      res_rej <= full;
    end
    if (ctl.tick_exec) begin
      res_ran  <= ran_now;
      res_fin  <= fin_now;
      res_slot <= sel;
      res_wt   <= fin_now ? clamp_time(wt_raw) : '0;
      res_ta   <= fin_now ? clamp_time(ta_raw) : '0;
      cmp_v    <= 1'b0;
      scan_x   <= '0;
      best     <= sel;
      best_pr  <= PRIO_NONE;
      best_arr <= '0;
    end
    if (ctl.scan_run) begin
      cmp_v   <= issue;
      cmp_idx <= scan_x[SLOT_W-1:0];
      if (issue) begin
        scan_x <= scan_x + CNT_W'(1);
      end
      if (cmp_v && cand_better) begin
        best     <= cmp_idx;
        best_pr  <= pri_rd;
        best_arr <= arr_rd;
      end
      if (!sts.scan_busy) begin
        res_sw <= (best != res_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      time_now <= '0;
      sel      <= '0;
      done     <= '0;
    end else begin
      if (ctl.load_exec && !full) begin
        done[wr_slot] <= 1'b0;
        count         <= count + CNT_W'(1);
        if ((time_now == '0) && (({1'b0, sel} >= count) || (arr_q < arr_rd))) begin
          sel <= wr_slot;
        end
      end
      if (ctl.tick_exec) begin
        if (fin_now) begin
          done[sel] <= 1'b1;
        end
        if (time_now != TIME_MAX) begin
          time_now <= time_now + TIME_W'(1);
        end
      end
      if (ctl.scan_run && !sts.scan_busy) begin
        sel <= best;
      end
      if (ctl.clear_exec) begin
        done     <= '0;
        count    <= '0;
        time_now <= '0;
        sel      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res.load_rejected <= res_rej;
      res.current_time  <= time_now;
      res.ran_valid     <= res_ran;
      res.ran_slot      <= (func_q == FN_TICK) ? res_slot : sel;
      res.finished      <= res_fin;
      res.waiting_time  <= res_wt;
      res.turnaround    <= res_ta;
      res.next_slot     <= sel;
      res.switched      <= res_sw;
      res.all_done      <= all_done;
    end
  end

endmodule

// ----- hw/rtl/preemptive_priority_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Load and clear run an execute state and then the result state; unused codes go straight to
// the result state. A tick runs an execute state, a scan of one table slot per cycle through
// the registered memory read port with a drain of the compare stage, and the result state.
// The unit takes a new item only once the last one has loaded its result; a waiting
// result holds the controller and keeps the input not ready. Reset clears task count, time,
// selection, done flags and the result valid.
module preemptive_priority_scheduler_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pps_pkg::item_in_t  cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output pps_pkg::item_out_t res
);
  import pps_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .func      (cmd.func),
    .sts       (sts),
    .cmd_ready (cmd_ready),
    .ctl       (ctl)
  );

  pps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// ----- hw/rtl/pps_chk.sv -----
`timescale 1ns / 1ps
// Checker: port-level assertions of the priority scheduler, bound to the top level.
`include "assert_macros.svh"
module pps_chk (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input pps_pkg::item_out_t res
);
  import pps_pkg::*;

  `PPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
  `PPS_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready)
  `PPS_ASSERT_NOW(a_switch, res_valid && res.switched, res.ran_slot != res.next_slot)
  `PPS_ASSERT_NOW(a_times, res_valid && res.finished, res.turnaround >= res.waiting_time)

endmodule

bind preemptive_priority_scheduler_unit pps_chk u_pps_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the preemptive priority scheduler: directed table, random schedules, long bursts.
module testbench;
  import pps_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int FINAL_TICKS = 20;

  typedef struct {
    item_in_t  cmd;
    bit        typed;
    item_out_t res;
  } probe_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  item_in_t  cmd;
  logic      res_valid;
  logic      res_ready;
  item_out_t res;

  logic [TIME_W-1:0] tab_arrival [MAX_TASKS];
  logic [TIME_W-1:0] tab_burst   [MAX_TASKS];
  logic [TIME_W-1:0] tab_left    [MAX_TASKS];
  logic [PRIO_W-1:0] tab_prio    [MAX_TASKS];
  logic              tab_done    [MAX_TASKS];
  int unsigned       sched_count;
  logic [TIME_W-1:0] sched_time;
  int unsigned       sched_sel;

  item_out_t   results_due [$];
  item_out_t   want;
  probe_row_t  directed_rows [$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned finishes_seen;
  int unsigned rejects_seen;
  int unsigned mismatch_count;
  int unsigned stall_cycles;

  preemptive_priority_scheduler_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always #1 clk = ~clk;

  function automatic item_in_t mk_cmd(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b, input logic [PRIO_W-1:0] p);
    item_in_t c;
    c.func = f;
    c.arrival = a;
    c.burst = b;
    c.priority_req = p;
    return c;
  endfunction

  function automatic item_out_t mk_res(input logic rej, input logic [TIME_W-1:0] t,
                                       input logic ran, input logic [SLOT_W-1:0] rs,
                                       input logic fin, input logic [TIME_W-1:0] wt,
                                       input logic [TIME_W-1:0] ta, input logic [SLOT_W-1:0] ns,
                                       input logic sw, input logic ad);
    item_out_t r;
    r.load_rejected = rej;
    r.current_time = t;
    r.ran_valid = ran;
    r.ran_slot = rs;
    r.finished = fin;
    r.waiting_time = wt;
    r.turnaround = ta;
    r.next_slot = ns;
    r.switched = sw;
    r.all_done = ad;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] clamp_time(input int v);
    if (v < 0) return '0;
    if (v > int'(TIME_MAX)) return TIME_MAX;
    return TIME_W'(v);
  endfunction

  function automatic bit sched_all_done();
    for (int x = 0; x < sched_count; x++)
      if (!tab_done[x]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void sched_reset();
    for (int x = 0; x < MAX_TASKS; x++) begin
      tab_arrival[x] = '0;
      tab_burst[x] = '0;
      tab_left[x] = '0;
      tab_prio[x] = '0;
      tab_done[x] = 1'b0;
    end
    sched_count = 0;
    sched_time = '0;
    sched_sel = 0;
  endfunction

  function automatic item_out_t schedule_step(input item_in_t c);
    item_out_t   r;
    int unsigned slot;
    int unsigned best;
    int unsigned best_pr;
    logic [TIME_W-1:0] best_arr;
    int          fin_t;
    r = '0;
    r.ran_slot = SLOT_W'(sched_sel);
    case (c.func)
      FN_LOAD: begin
        if (sched_count >= MAX_TASKS) begin
          r.load_rejected = 1'b1;
        end else begin
          slot = sched_count;
          tab_arrival[slot] = c.arrival;
          tab_burst[slot] = c.burst;
          tab_left[slot] = c.burst;
          tab_prio[slot] = c.priority_req;
          tab_done[slot] = 1'b0;
          if (sched_time == 0 &&
              (slot == 0 || sched_sel >= slot || c.arrival < tab_arrival[sched_sel]))
            sched_sel = slot;
          sched_count = slot + 1;
        end
        r.ran_slot = SLOT_W'(sched_sel);
      end
      FN_TICK: begin
        slot = sched_sel;
        if (slot < sched_count) begin
          if (tab_left[slot] != 0 && tab_arrival[slot] <= sched_time) begin
            tab_left[slot] = tab_left[slot] - 1'b1;
            r.ran_valid = 1'b1;
          end
          if (tab_left[slot] == 0 && !tab_done[slot]) begin
            fin_t = int'(sched_time) + 1;
            tab_done[slot] = 1'b1;
            r.finished = 1'b1;
            r.waiting_time = clamp_time(fin_t - int'(tab_burst[slot]) - int'(tab_arrival[slot]));
            r.turnaround = clamp_time(fin_t - int'(tab_arrival[slot]));
          end
        end
        if (sched_time != TIME_MAX) sched_time = sched_time + 1'b1;
        best = slot;
        best_pr = PRIO_NONE;
        best_arr = '0;
        for (int x = 0; x < sched_count; x++) begin
          if (tab_arrival[x] <= sched_time && !tab_done[x]) begin
            if (tab_prio[x] < best_pr ||
                (tab_prio[x] == best_pr && best_pr < PRIO_NONE && tab_arrival[x] < best_arr)) begin
              best_pr = tab_prio[x];
              best_arr = tab_arrival[x];
              best = x;
            end
          end
        end
        sched_sel = best;
        r.switched = (sched_sel != slot);
      end
      FN_CLEAR: begin
        for (int x = 0; x < MAX_TASKS; x++) tab_done[x] = 1'b0;
        sched_count = 0;
        sched_time = '0;
        sched_sel = 0;
        r.ran_slot = '0;
      end
      default: begin
      end
    endcase
    r.current_time = sched_time;
    r.next_slot = SLOT_W'(sched_sel);
    r.all_done = sched_all_done();
    return r;
  endfunction

  task automatic send_item(input item_in_t c, input bit typed, input item_out_t typed_res);
    item_out_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    pred = schedule_step(c);
    results_due.push_back(typed ? typed_res : pred);
    items_sent++;
    if (c.func == FN_TICK) ticks_sent++;
  endtask

  task automatic send_cmd(input item_in_t c);
    send_item(c, 1'b0, '0);
  endtask

  function automatic item_in_t rand_load();
    item_in_t c;
    int       pick;
    c.func = FN_LOAD;
    pick = $urandom_range(99);
    if (pick < 70) c.arrival = TIME_W'($urandom_range(30));
    else if (pick < 90) c.arrival = TIME_W'($urandom_range(200));
    else c.arrival = TIME_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) c.burst = '0;
    else if (pick < 85) c.burst = TIME_W'($urandom_range(1, 12));
    else if (pick < 95) c.burst = TIME_W'($urandom_range(13, 300));
    else c.burst = TIME_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) c.priority_req = PRIO_W'($urandom_range(7));
    else if (pick < 85) c.priority_req = PRIO_W'($urandom_range(998));
    else if (pick < 93) c.priority_req = PRIO_W'($urandom_range(999, 1023));
    else c.priority_req = PRIO_W'($urandom);
    return c;
  endfunction

  function automatic item_in_t rand_noise();
    return mk_cmd(FUNC_W'($urandom), TIME_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom));
  endfunction

  task automatic run_schedules(input int unsigned target);
    int unsigned start;
    int unsigned n_load;
    int unsigned n_tick;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(9) != 0) begin
        send_cmd(mk_cmd(FN_CLEAR, TIME_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom)));
      end
      n_load = ($urandom_range(9) == 0) ? $urandom_range(MAX_TASKS + 1, MAX_TASKS + 3)
                                        : $urandom_range(1, MAX_TASKS);
      repeat (n_load) send_cmd(rand_load());
      n_tick = $urandom_range(4, 60);
      repeat (n_tick) begin
        if ($urandom_range(15) == 0) send_cmd(rand_noise());
        else if ($urandom_range(19) == 0) send_cmd(rand_load());
        else send_cmd(mk_cmd(FN_TICK, TIME_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom)));
      end
    end
  endtask

  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (res.finished) finishes_seen++;
      if (res.load_rejected) rejects_seen++;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: result with nothing expected: %p", res);
      end else begin
        want = results_due.pop_front();
        if (res.load_rejected !== want.load_rejected || res.current_time !== want.current_time ||
            res.ran_valid !== want.ran_valid || res.ran_slot !== want.ran_slot ||
            res.finished !== want.finished || res.waiting_time !== want.waiting_time ||
            res.turnaround !== want.turnaround || res.next_slot !== want.next_slot ||
            res.switched !== want.switched || res.all_done !== want.all_done) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result %0d mismatch", results_seen);
            $display("  expected %p", want);
            $display("  actual   %p", res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles, %0d results pending",
               stall_cycles, results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    probe_row_t row;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    hold_req = 1'b0;
    tx_idle_pct = 26;
    rx_idle_pct = 75;
    items_sent = 0;
    ticks_sent = 0;
    results_seen = 0;
    finishes_seen = 0;
    rejects_seen = 0;
    mismatch_count = 0;
    stall_cycles = 0;
    sched_reset();

    row.typed = 1'b1;
    row.cmd = mk_cmd(FN_TICK, '0, '0, '0);
    row.res = mk_res(0, 1, 0, 0, 0, 0, 0, 0, 0, 1);
    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_UNUSED, '1, '1, '1);
    row.res = mk_res(0, 1, 0, 0, 0, 0, 0, 0, 0, 1);
    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_CLEAR, '1, '1, '1);
    row.res = mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd5, 16'd0, 10'd7);
    row.res = mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_TICK, '0, '0, '0);
    row.res = mk_res(0, 1, 0, 0, 1, 0, 0, 0, 0, 1);
    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_CLEAR, '0, '0, '0);
    row.res = mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    directed_rows.push_back(row);
    row.typed = 1'b0;
    row.res = '0;
    foreach (directed_rows[i]) begin
    end
    row.cmd = mk_cmd(FN_LOAD, 16'd3, 16'd2, 10'd4);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd0, 16'd0, 10'd0);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'hFFFF, 16'hFFFF, 10'd998); directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd0, 16'd3, 10'd999);       directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd0, 16'd3, 10'd1023);      directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd1, 16'd2, 10'd4);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd1, 16'd1, 10'd4);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd2, 16'd4, 10'd0);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd0, 16'hFFFF, 10'd998);    directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd4, 16'd1, 10'd2);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd6, 16'd2, 10'd1);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd8, 16'd1, 10'd3);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd10, 16'd2, 10'd5);        directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd2, 16'd1, 10'd0);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd0, 16'd2, 10'd10);        directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'd7, 16'd3, 10'd4);         directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_LOAD, 16'hFFFF, 16'hFFFF, 10'h3FF); directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_TICK, '0, '0, '0);                  directed_rows.push_back(row);
    row.cmd = mk_cmd(FN_TICK, '1, '1, '1);                  directed_rows.push_back(row);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i].cmd, directed_rows[i].typed,
                                         directed_rows[i].res);

    run_schedules(600);
    tx_idle_pct = 75;
    rx_idle_pct = 26;
    run_schedules(600);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    run_schedules(600);

    send_cmd(mk_cmd(FN_CLEAR, '0, '0, '0));
    send_cmd(mk_cmd(FN_LOAD, 16'd0, 16'hFFFF, 10'd5));
    send_cmd(mk_cmd(FN_LOAD, 16'd0, 16'd2, 10'd900));
    send_cmd(mk_cmd(FN_LOAD, 16'hFFFF, 16'd1, 10'd0));
    repeat (FINAL_TICKS) send_cmd(mk_cmd(FN_TICK, '0, '0, '0));

    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d ticks) over three idle mixes, a long output stall",
             items_sent, ticks_sent);
    $display("and a long-burst schedule; %0d results, %0d completions, %0d rejected loads",
             results_seen, finishes_seen, rejects_seen);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
